// ===== rtl/core/spq_pkg.sv =====
package spq_pkg;

    localparam int DATA_W       = 32;
    localparam int STATUS_W     = 2;
    localparam int OCC_W        = 5;
    localparam int CAPACITY_DEF = 16;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_REMOVE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // One stored entry of the sorted list.
    typedef struct packed {
        logic signed [DATA_W-1:0] data;
        logic signed [DATA_W-1:0] prio;
    } entry_t;

    // Operation broadcast to every cell in the chain.
    typedef struct packed {
        logic   ins;      // insert that the queue has room for
        logic   rem;      // remove from a non-empty queue
        entry_t new_ent;  // entry carried by an insert
    } cell_ctl_t;

endpackage

// ===== rtl/core/spq_cell.sv =====
module spq_cell
    import spq_pkg::*;
(
    input  logic      aclk,
    input  cell_ctl_t ctl,
    input  logic      occupied,
    input  logic      keep_left,
    input  entry_t    left_ent,
    input  entry_t    right_ent,
    output logic      keep,
    output entry_t    ent
);

    entry_t ent_reg;
    entry_t ent_next;

    // The cell stays put on an insert when it holds an entry that is served
    // no later than the new one; these cells always form a prefix of the chain.
    assign keep = occupied && (ent_reg.prio <= ctl.new_ent.prio);
    assign ent  = ent_reg;

    always_comb begin
        ent_next = ent_reg;
        if (ctl.ins && !keep) begin
            ent_next = keep_left ? ctl.new_ent : left_ent;
        end else if (ctl.rem) begin
            ent_next = right_ent;
        end
    end

    always_ff @(posedge aclk) begin
        ent_reg <= ent_next;
    end

endmodule

// ===== rtl/core/sorted_priority_queue.sv =====
// Sorted priority queue, smallest priority number first.
// Input channel (s_*): one word per operation. s_func selects an insert of
// s_item_data with s_item_priority, or a remove of the head entry. Entries
// of equal priority leave in the order in which they were inserted.
// Result channel (m_*): exactly one word per accepted operation, holding
// the status (ok, empty on remove, full on insert), the removed entry
// (zero unless a remove succeeded) and the occupancy after the operation.
//
// The store is a chain of CAPACITY identical cells. On an insert every
// cell compares its own priority with the new one in parallel, and the
// cells behind the insertion point shift one place down the chain. On a
// remove every cell takes the entry of its right neighbor. Each operation
// therefore updates all cells at once; the result word appears in the
// output register in the cycle after acceptance, and a new operation is
// taken in every cycle with s_ready high. The depth of the compare is one
// 32-bit signed compare per cell plus the occupancy decode of the entry count.
//
// While a result word waits for m_ready, s_ready follows m_ready, so the
// queue takes the next operation in the same cycle that the waiting word
// leaves. Reset empties the queue and drops any pending result word.
module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,

    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_func,
    input  logic signed [DATA_W-1:0]   s_item_data,
    input  logic signed [DATA_W-1:0]   s_item_priority,

    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [STATUS_W-1:0]        m_status,
    output logic signed [DATA_W-1:0]   m_removed_data,
    output logic signed [DATA_W-1:0]   m_removed_priority,
    output logic [OCC_W-1:0]           m_occupancy
);

    localparam int CW = $clog2(CAPACITY + 1);

    // Entry count; cells below it hold valid entries in sorted order.
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    // Result word register.
    logic                      m_valid_reg;
    logic                      m_valid_next;
    logic [STATUS_W-1:0]       status_reg;
    logic [STATUS_W-1:0]       status_next;
    logic signed [DATA_W-1:0]  rdata_reg;
    logic signed [DATA_W-1:0]  rdata_next;
    logic signed [DATA_W-1:0]  rprio_reg;
    logic signed [DATA_W-1:0]  rprio_next;
    logic [OCC_W-1:0]          occ_reg;
    logic [OCC_W-1:0]          occ_next;

    logic      accept;
    logic      is_full;
    logic      is_empty;
    cell_ctl_t ctl;

    entry_t cell_ent  [CAPACITY];
    logic   cell_keep [CAPACITY];
    logic   cell_occ  [CAPACITY];

    // Occupancy is reported as the low bits of the count.
    logic [CW+OCC_W-1:0] count_wide;

    assign s_ready  = !m_valid_reg || m_ready;
    assign accept   = s_valid && s_ready;
    assign is_full  = (count_reg == CW'(CAPACITY));
    assign is_empty = (count_reg == '0);

    assign ctl.ins          = accept && (s_func == FUNC_INSERT) && !is_full;
    assign ctl.rem          = accept && (s_func == FUNC_REMOVE) && !is_empty;
    assign ctl.new_ent.data = s_item_data;
    assign ctl.new_ent.prio = s_item_priority;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            entry_t left_ent;
            entry_t right_ent;
            logic   keep_left;

            assign cell_occ[gi] = (count_reg > CW'(gi));

            if (gi == 0) begin : g_head
                // On an insert the head takes the new entry whenever it does not keep its own.
                assign keep_left = 1'b1;
                assign left_ent  = ctl.new_ent;
            end else begin : g_body
                assign keep_left = cell_keep[gi-1];
                assign left_ent  = cell_ent[gi-1];
            end

            if (gi == CAPACITY - 1) begin : g_tail
                assign right_ent = cell_ent[gi];
            end else begin : g_inner
                assign right_ent = cell_ent[gi+1];
            end

            spq_cell u_cell (
                .aclk      (aclk),
                .ctl       (ctl),
                .occupied  (cell_occ[gi]),
                .keep_left (keep_left),
                .left_ent  (left_ent),
                .right_ent (right_ent),
                .keep      (cell_keep[gi]),
                .ent       (cell_ent[gi])
            );
        end
    endgenerate

    always_comb begin
        count_next = count_reg;
        if (ctl.ins) begin
            count_next = count_reg + CW'(1);
        end else if (ctl.rem) begin
            count_next = count_reg - CW'(1);
        end
    end

    assign count_wide = {{OCC_W{1'b0}}, count_next};

    always_comb begin
        m_valid_next = m_valid_reg;
        status_next  = status_reg;
        rdata_next   = rdata_reg;
        rprio_next   = rprio_reg;
        occ_next     = occ_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (accept) begin
            m_valid_next = 1'b1;
            status_next  = ST_OK;
            rdata_next   = '0;
            rprio_next   = '0;
            occ_next     = count_wide[OCC_W-1:0];
            if (s_func == FUNC_INSERT) begin
                if (is_full) begin
                    status_next = ST_FULL;
                end
            end else begin
                if (is_empty) begin
                    status_next = ST_EMPTY;
                end else begin
                    rdata_next = cell_ent[0].data;
                    rprio_next = cell_ent[0].prio;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg <= status_next;
        rdata_reg  <= rdata_next;
        rprio_reg  <= rprio_next;
        occ_reg    <= occ_next;
    end

    assign m_valid            = m_valid_reg;
    assign m_status           = status_reg;
    assign m_removed_data     = rdata_reg;
    assign m_removed_priority = rprio_reg;
    assign m_occupancy        = occ_reg;

endmodule

// ===== rtl/core/spq_checker.sv =====
module spq_checker
    import spq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_valid,
    input logic                      s_ready,
    input logic                      m_valid,
    input logic                      m_ready,
    input logic [STATUS_W-1:0]       m_status,
    input logic signed [DATA_W-1:0]  m_removed_data,
    input logic signed [DATA_W-1:0]  m_removed_priority,
    input logic [OCC_W-1:0]          m_occupancy
);

    localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(CAPACITY % (1 << OCC_W));

    // A refused remove reports an empty queue and no entry.
    a_empty_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_EMPTY) |->
            (m_occupancy == '0) && (m_removed_data == '0) && (m_removed_priority == '0))
        else $error("empty status with nonzero fields");

    // A refused insert reports a full queue and no entry.
    a_full_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_FULL) |->
            (m_occupancy == OCC_FULL) && (m_removed_data == '0) && (m_removed_priority == '0))
        else $error("full status with wrong fields");

    // Every accepted operation yields a result word in the next cycle.
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("no result word after accepted operation");

    // A stalled result word holds.
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_occupancy)
            && $stable(m_removed_data) && $stable(m_removed_priority))
        else $error("result word changed while stalled");

endmodule

bind sorted_priority_queue spq_checker #(.CAPACITY(CAPACITY)) u_spq_checker (
    .aclk               (aclk),
    .aresetn            (aresetn),
    .s_valid            (s_valid),
    .s_ready            (s_ready),
    .m_valid            (m_valid),
    .m_ready            (m_ready),
    .m_status           (m_status),
    .m_removed_data     (m_removed_data),
    .m_removed_priority (m_removed_priority),
    .m_occupancy        (m_occupancy)
);
